@@ rtl/core/c8ie_pkg.sv @@
// Package for the CHIP-8 instruction execute core: opcode, function and
// status codes, and the status type. Depends on nothing.
package c8ie_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNSUPP    = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_UNDERFLOW = 2'd3;

    // Major opcodes (top nibble of the instruction word).
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [15:0] INS_RET = 16'h00EE;
    localparam logic [11:0] ADDR_MASK = 12'hFFF;

    // ALU function codes (low nibble of 8xyN).
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Fx codes (low byte).
    localparam logic [7:0] FX_LD_DT = 8'h07;
    localparam logic [7:0] FX_DT_LD = 8'h15;
    localparam logic [7:0] FX_ST_LD = 8'h18;
    localparam logic [7:0] FX_ADD_I = 8'h1E;

    localparam logic [3:0] REG_VF = 4'hF;
    localparam logic [3:0] REG_V0 = 4'h0;

endpackage

@@ rtl/core/chip8_instruction_execute.sv @@
// CHIP-8 instruction execute core: register file, index, pc, return stack
// and timers, one instruction per beat. Depends on c8ie_pkg.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_instruction
//   result    out        o_valid / i_ready  o_next_pc, o_written_value,
//                                           o_flag_value, o_index_value, o_status
//
// An accepted beat executes against the state from the input register, and its
// result shows in the result register the cycle after. One instruction per cycle
// is sustained unless the result stalls; Vx and Vy are read from the register
// file memory at acceptance, with the executing instruction forwarded.
// Synchronous active-low reset clears the state; pc starts at PROGRAM_START.
// A stalled result holds the input register; o_ready drops only when both hold.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_instruction,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [11:0]          o_next_pc,
    output logic [7:0]           o_written_value,
    output logic [7:0]           o_flag_value,
    output logic [11:0]          o_index_value,
    output c8ie_pkg::t_status    o_status
);
    import c8ie_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    // Input stage.
    logic        r_in_valid;
    logic [15:0] r_instr;
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;

    // Architectural state.
    logic [7:0]     r_regs [16];
    logic [7:0]     r_vf;
    logic [7:0]     r_v0;
    logic [11:0]    r_pc;
    logic [11:0]    r_index;
    logic [7:0]     r_delay;
    logic [7:0]     r_sound;
    logic [SPW-1:0] r_sp;
    logic [11:0]    r_stack [STACK_DEPTH];
    logic [11:0]    r_tos;
    logic [11:0]    r_second;

    // Result stage.
    logic        r_out_valid;
    logic [11:0] r_out_pc;
    logic [7:0]  r_out_wr;
    logic [7:0]  r_out_vf;
    logic [11:0] r_out_index;
    t_status     r_out_status;

    logic        fire;
    logic        accept;
    logic [3:0]  op;
    logic [3:0]  fx;
    logic [3:0]  fn;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] pc2;
    logic [11:0] pc4;
    logic [8:0]  sum9;

    logic        wr_en;
    logic [7:0]  c_wr;
    logic        flag_en;
    logic [7:0]  c_flag;
    t_status     c_status;
    logic [11:0] c_next;
    logic [11:0] c_index;
    logic        push;
    logic        pop;
    logic        delay_we;
    logic        sound_we;
    logic [7:0]  n_vf;

    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;
    assign accept  = i_valid && o_ready;

    assign op   = r_instr[15:12];
    assign fx   = r_instr[11:8];
    assign fn   = r_instr[3:0];
    assign kk   = r_instr[7:0];
    assign nnn  = r_instr[11:0] & ADDR_MASK;
    assign pc2  = r_pc + 12'd2;
    assign pc4  = r_pc + 12'd4;
    assign sum9 = {1'b0, r_vx} + {1'b0, r_vy};

    always_comb begin
        wr_en    = 1'b0;
        c_wr     = 8'd0;
        flag_en  = 1'b0;
        c_flag   = 8'd0;
        c_status = ST_OK;
        c_next   = pc2;
        c_index  = r_index;
        push     = 1'b0;
        pop      = 1'b0;
        delay_we = 1'b0;
        sound_we = 1'b0;
        case (op)
            OP_SYS: begin
                if (r_instr == INS_RET) begin
                    if (r_sp == '0) begin
                        c_status = ST_UNDERFLOW;
                    end else begin
                        pop    = 1'b1;
                        c_next = r_tos;
                    end
                end else begin
                    c_status = ST_UNSUPP;
                end
            end
            OP_JP: c_next = nnn;
            OP_CALL: begin
                if (r_sp >= SPW'(STACK_DEPTH)) begin
                    c_status = ST_OVERFLOW;
                end else begin
                    push   = 1'b1;
                    c_next = nnn;
                end
            end
            OP_SE:  if (r_vx == kk) c_next = pc4;
            OP_SNE: if (r_vx != kk) c_next = pc4;
            OP_SEV: begin
                if (fn != 4'h0) c_status = ST_UNSUPP;
                else if (r_vx == r_vy) c_next = pc4;
            end
            OP_LD: begin
                wr_en = 1'b1;
                c_wr  = kk;
            end
            OP_ADD: begin
                wr_en = 1'b1;
                c_wr  = r_vx + kk;
            end
            OP_ALU: begin
                case (fn)
                    ALU_MOV: begin wr_en = 1'b1; c_wr = r_vy; end
                    ALU_OR:  begin wr_en = 1'b1; c_wr = r_vx | r_vy; end
                    ALU_AND: begin wr_en = 1'b1; c_wr = r_vx & r_vy; end
                    ALU_XOR: begin wr_en = 1'b1; c_wr = r_vx ^ r_vy; end
                    ALU_ADD: begin
                        wr_en   = 1'b1;
                        flag_en = 1'b1;
                        c_wr    = sum9[7:0];
                        c_flag  = {7'd0, sum9[8]};
                    end
                    ALU_SUB: begin
                        wr_en   = 1'b1;
                        flag_en = 1'b1;
                        c_wr    = r_vx - r_vy;
                        c_flag  = {7'd0, r_vx >= r_vy};
                    end
                    ALU_SHR: begin
                        wr_en   = 1'b1;
                        flag_en = 1'b1;
                        c_wr    = {1'b0, r_vx[7:1]};
                        c_flag  = {7'd0, r_vx[0]};
                    end
                    ALU_SUBN: begin
                        wr_en   = 1'b1;
                        flag_en = 1'b1;
                        c_wr    = r_vy - r_vx;
                        c_flag  = {7'd0, r_vy >= r_vx};
                    end
                    ALU_SHL: begin
                        wr_en   = 1'b1;
                        flag_en = 1'b1;
                        c_wr    = {r_vx[6:0], 1'b0};
                        c_flag  = {7'd0, r_vx[7]};
                    end
                    default: c_status = ST_UNSUPP;
                endcase
            end
            OP_SNEV: begin
                if (fn != 4'h0) c_status = ST_UNSUPP;
                else if (r_vx != r_vy) c_next = pc4;
            end
            OP_LDI:  c_index = nnn;
            OP_JPV0: c_next = nnn + {4'd0, r_v0};
            OP_MISC: begin
                case (kk)
                    FX_LD_DT: begin wr_en = 1'b1; c_wr = r_delay; end
                    FX_DT_LD: delay_we = 1'b1;
                    FX_ST_LD: sound_we = 1'b1;
                    FX_ADD_I: c_index = r_index + {4'd0, r_vx};
                    default:  c_status = ST_UNSUPP;
                endcase
            end
            default: c_status = ST_UNSUPP;
        endcase
    end

    // VF lives in its own register; the flag write lands after the result write.
    always_comb begin
        n_vf = r_vf;
        if (fire) begin
            if (flag_en) begin
                n_vf = c_flag;
            end else if (wr_en && fx == REG_VF) begin
                n_vf = c_wr;
            end
        end
    end

    // Register file memory: one write port, two registered read ports that
    // see the result of the instruction executing in the same cycle. The
    // synchronous reset clears every entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_regs[k] <= 8'd0;
            end
        end else if (fire && wr_en) begin
            r_regs[fx] <= c_wr;
        end
        if (accept) begin
            if (i_instruction[11:8] == REG_VF) begin
                r_vx <= n_vf;
            end else if (fire && wr_en && fx == i_instruction[11:8]) begin
                r_vx <= c_wr;
            end else begin
                r_vx <= r_regs[i_instruction[11:8]];
            end
            if (i_instruction[7:4] == REG_VF) begin
                r_vy <= n_vf;
            end else if (fire && wr_en && fx == i_instruction[7:4]) begin
                r_vy <= c_wr;
            end else begin
                r_vy <= r_regs[i_instruction[7:4]];
            end
            r_instr <= i_instruction;
        end
    end

    // Return stack memory. The top entry and the one below it are kept in
    // registers so a return needs no same-cycle memory read.
    always_ff @(posedge i_clk) begin
        if (fire && push) begin
            r_stack[r_sp[AW-1:0]] <= pc2;
            r_tos                 <= pc2;
            r_second              <= r_tos;
        end else if (fire && pop) begin
            r_tos    <= r_second;
            r_second <= r_stack[r_sp[AW-1:0] - AW'(3)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vf        <= 8'd0;
            r_v0        <= 8'd0;
            r_pc        <= 12'(PROGRAM_START);
            r_index     <= 12'd0;
            r_delay     <= 8'd0;
            r_sound     <= 8'd0;
            r_sp        <= '0;
        end else begin
            r_in_valid  <= accept || (r_in_valid && !fire);
            r_out_valid <= fire || (r_out_valid && !i_ready);
            r_vf        <= n_vf;
            if (fire) begin
                r_pc    <= c_next;
                r_index <= c_index;
                if (wr_en && fx == REG_V0) r_v0 <= c_wr;
                if (delay_we) r_delay <= r_vx;
                if (sound_we) r_sound <= r_vx;
                if (push) begin
                    r_sp <= r_sp + SPW'(1);
                end else if (pop) begin
                    r_sp <= r_sp - SPW'(1);
                end
            end
        end
    end

    // Result register: loads on every executed beat and holds while the
    // result waits.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_pc     <= c_next;
            r_out_wr     <= c_wr;
            r_out_vf     <= n_vf;
            r_out_index  <= c_index;
            r_out_status <= c_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_next_pc       = r_out_pc;
    assign o_written_value = r_out_wr;
    assign o_flag_value    = r_out_vf;
    assign o_index_value   = r_out_index;
    assign o_status        = r_out_status;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && c_status == ST_OVERFLOW |=> $stable(r_sp))
        else $error("stack pointer moved on overflow");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && push |=> r_tos == $past(pc2) && r_pc == $past(nnn))
        else $error("call did not push return address");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input stalled without a stalled result");

endmodule

@@ tb/sv/chip8_instruction_execute_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the CHIP-8 instruction execute core: a queue-fed driver that runs
// a local execution model, a checking monitor, and idling phases. Depends on c8ie_pkg and the RTL.
module chip8_instruction_execute_test;
    import c8ie_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int PROGRAM_START = 512;
    localparam int HOLD_CYCLES   = 400;

    // Encodings the core does not execute.
    localparam logic [15:0] INS_CLS   = 16'h00E0;
    localparam logic [3:0]  OP_RND    = 4'hC;
    localparam logic [3:0]  OP_DRW    = 4'hD;
    localparam logic [3:0]  OP_SKP    = 4'hE;
    localparam logic [3:0]  ALU_UNDEF = 4'h8;
    localparam logic [7:0]  FX_BCD    = 8'h33;

    typedef struct packed {
        logic [15:0] instr;
        logic [11:0] next_pc;
        logic [7:0]  written;
        logic [7:0]  flag;
        logic [11:0] index;
        t_status     status;
    } t_exec_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_instruction = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [11:0] o_next_pc;
    logic [7:0]  o_written_value;
    logic [7:0]  o_flag_value;
    logic [11:0] o_index_value;
    t_status     o_status;

    logic [15:0]  instr_q[$];
    t_exec_result result_q[$];

    // Local copy of the architectural state.
    logic [7:0]  vreg [16];
    logic [11:0] idx_q;
    logic [11:0] pc_q;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          sp_q;
    logic [7:0]  delay_q;
    logic [7:0]  sound_q;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cnt = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;

    int mismatch_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int directed_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    logic [3:0] alu_codes [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                  ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};
    logic [7:0] fx_codes [4] = '{FX_LD_DT, FX_DT_LD, FX_ST_LD, FX_ADD_I};

    chip8_instruction_execute #(
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_START (PROGRAM_START)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_instruction   (i_instruction),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_next_pc       (o_next_pc),
        .o_written_value (o_written_value),
        .o_flag_value    (o_flag_value),
        .o_index_value   (o_index_value),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic void reset_model();
        for (int k = 0; k < 16; k++) vreg[k] = 8'h00;
        idx_q   = 12'h000;
        pc_q    = PROGRAM_START[11:0];
        sp_q    = 0;
        delay_q = 8'h00;
        sound_q = 8'h00;
    endfunction

    function automatic t_exec_result execute_instr(input logic [15:0] w);
        logic [3:0]  op, x, y, n;
        logic [7:0]  kk, vx, vy, res, flg;
        logic [11:0] nnn, pc2, nxt;
        logic [8:0]  sum;
        logic        wr_en, flag_en;
        t_exec_result r;
        op  = w[15:12];
        x   = w[11:8];
        y   = w[7:4];
        n   = w[3:0];
        kk  = w[7:0];
        nnn = w[11:0];
        vx  = vreg[x];
        vy  = vreg[y];
        pc2 = pc_q + 12'd2;
        nxt = pc2;
        res = 8'h00;
        flg = 8'h00;
        wr_en = 1'b0;
        flag_en = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_SYS: begin
                if (w == INS_RET) begin
                    if (sp_q == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        sp_q--;
                        nxt = ret_stack[sp_q];
                    end
                end else begin
                    r.status = ST_UNSUPP;
                end
            end
            OP_JP: nxt = nnn;
            OP_CALL: begin
                if (sp_q >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    ret_stack[sp_q] = pc2;
                    sp_q++;
                    nxt = nnn;
                end
            end
            OP_SE:  if (vx == kk) nxt = pc2 + 12'd2;
            OP_SNE: if (vx != kk) nxt = pc2 + 12'd2;
            OP_SEV: begin
                if (n != 4'h0) r.status = ST_UNSUPP;
                else if (vx == vy) nxt = pc2 + 12'd2;
            end
            OP_LD: begin
                res = kk;
                wr_en = 1'b1;
            end
            OP_ADD: begin
                res = vx + kk;
                wr_en = 1'b1;
            end
            OP_ALU: begin
                wr_en = 1'b1;
                flag_en = 1'b1;
                case (n)
                    ALU_MOV: begin res = vy; flag_en = 1'b0; end
                    ALU_OR:  begin res = vx | vy; flag_en = 1'b0; end
                    ALU_AND: begin res = vx & vy; flag_en = 1'b0; end
                    ALU_XOR: begin res = vx ^ vy; flag_en = 1'b0; end
                    ALU_ADD: begin
                        sum = vx + vy;
                        res = sum[7:0];
                        flg = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        res = vx - vy;
                        flg = {7'd0, vx >= vy};
                    end
                    ALU_SHR: begin
                        res = vx >> 1;
                        flg = {7'd0, vx[0]};
                    end
                    ALU_SUBN: begin
                        res = vy - vx;
                        flg = {7'd0, vy >= vx};
                    end
                    ALU_SHL: begin
                        res = vx << 1;
                        flg = {7'd0, vx[7]};
                    end
                    default: begin
                        wr_en = 1'b0;
                        flag_en = 1'b0;
                        r.status = ST_UNSUPP;
                    end
                endcase
            end
            OP_SNEV: begin
                if (n != 4'h0) r.status = ST_UNSUPP;
                else if (vx != vy) nxt = pc2 + 12'd2;
            end
            OP_LDI:  idx_q = nnn;
            OP_JPV0: nxt = nnn + {4'd0, vreg[REG_V0]};
            OP_MISC: begin
                case (kk)
                    FX_LD_DT: begin
                        res = delay_q;
                        wr_en = 1'b1;
                    end
                    FX_DT_LD: delay_q = vx;
                    FX_ST_LD: sound_q = vx;
                    FX_ADD_I: idx_q = idx_q + {4'd0, vx};
                    default:  r.status = ST_UNSUPP;
                endcase
            end
            default: r.status = ST_UNSUPP;
        endcase
        // The result lands first, so with x = F the flag wins.
        if (wr_en) vreg[x] = res;
        if (flag_en) vreg[REG_VF] = flg;
        pc_q = nxt;
        r.instr   = w;
        r.next_pc = nxt;
        r.written = wr_en ? res : 8'h00;
        r.flag    = vreg[REG_VF];
        r.index   = idx_q;
        return r;
    endfunction

    function automatic logic [3:0] pick_reg();
        logic [3:0] r;
        r = 4'($urandom);
        case ($urandom_range(0, 3))
            0: r = REG_VF;
            1: r[3:2] = 2'b00;
            default: ;
        endcase
        return r;
    endfunction

    // Bytes drawn from a small pool make register matches, carries and borrows common.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'h01;
            2: b = 8'h7F;
            3: b = 8'h80;
            4: b = 8'hFE;
            5: b = 8'hFF;
            default: ;
        endcase
        return b;
    endfunction

    task automatic add_random_items(input int count);
        int         k, j, sel;
        logic [3:0] x, y, n;
        logic [7:0] kk;
        logic [11:0] nnn;
        logic [15:0] w;
        for (k = 0; k < count; k++) begin
            x   = pick_reg();
            y   = pick_reg();
            kk  = pick_byte();
            nnn = 12'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                // Run the return stack past full, or past empty.
                for (j = 0; j < STACK_DEPTH + 2; j++) begin
                    nnn = 12'($urandom);
                    instr_q.push_back(sel == 0 ? {OP_CALL, nnn} : INS_RET);
                end
                continue;
            end
            if (sel < 22) begin
                n = alu_codes[$urandom_range(0, 8)];
                if ($urandom_range(0, 7) == 0) n = 4'($urandom);
                w = {OP_ALU, x, y, n};
            end else if (sel < 37) begin
                w = {OP_LD, x, kk};
            end else if (sel < 45) begin
                w = {OP_ADD, x, kk};
            end else if (sel < 57) begin
                w = {($urandom_range(0, 1) == 0) ? OP_SE : OP_SNE, x, kk};
            end else if (sel < 65) begin
                n = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
                w = {($urandom_range(0, 1) == 0) ? OP_SEV : OP_SNEV, x, y, n};
            end else if (sel < 71) begin
                w = {OP_CALL, nnn};
            end else if (sel < 77) begin
                w = INS_RET;
            end else if (sel < 81) begin
                w = {($urandom_range(0, 1) == 0) ? OP_JP : OP_JPV0, nnn};
            end else if (sel < 89) begin
                if ($urandom_range(0, 4) == 0) w = {OP_LDI, nnn};
                else w = {OP_MISC, x, fx_codes[$urandom_range(0, 3)]};
            end else begin
                w = 16'($urandom);
            end
            instr_q.push_back(w);
        end
    endtask

    task automatic wait_drained();
        while (instr_q.size() != 0 || i_valid || result_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] instr,
                                   input logic [15:0] got, input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t ns: %s wrong for instruction %h: got %h, want %h",
                     $time, what, instr, got, want);
    endtask

    always @(posedge i_clk) begin : driver
        logic fire;
        if (!i_rst_n) begin
            reset_model();
            i_valid <= 1'b0;
            i_instruction <= '0;
        end else begin
            fire = i_valid && o_ready;
            if (fire) begin
                result_q.push_back(execute_instr(i_instruction));
                sent_count++;
            end
            if (i_valid && !fire) begin
                // Beat still waiting; hold valid and payload.
            end else if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_instruction <= instr_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receiver_hold
        if (!i_rst_n) begin
            hold_cnt <= 0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_used) begin
            hold_cnt <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_exec_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 16'h0000,
                                    {4'd0, o_next_pc}, 16'h0000);
                end else begin
                    want = result_q.pop_front();
                    checked_count++;
                    status_seen[want.status]++;
                    if (o_next_pc !== want.next_pc)
                        report_mismatch("next_pc", want.instr, {4'd0, o_next_pc},
                                        {4'd0, want.next_pc});
                    if (o_written_value !== want.written)
                        report_mismatch("written_value", want.instr, {8'd0, o_written_value},
                                        {8'd0, want.written});
                    if (o_flag_value !== want.flag)
                        report_mismatch("flag_value", want.instr, {8'd0, o_flag_value},
                                        {8'd0, want.flag});
                    if (o_index_value !== want.index)
                        report_mismatch("index_value", want.instr, {4'd0, o_index_value},
                                        {4'd0, want.index});
                    if (o_status !== want.status)
                        report_mismatch("status", want.instr, {14'd0, o_status},
                                        {14'd0, want.status});
                end
            end
            i_ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        int ph;
        instr_q.push_back(INS_RET);                               // return on an empty stack
        instr_q.push_back(INS_CLS);
        instr_q.push_back({OP_LD, REG_V0, 8'hFF});
        instr_q.push_back({OP_LD, 4'h1, 8'h01});
        instr_q.push_back({OP_ALU, REG_V0, 4'h1, ALU_ADD});       // carry out
        instr_q.push_back({OP_ALU, REG_V0, 4'h1, ALU_SUB});       // borrow
        instr_q.push_back({OP_ALU, 4'h1, 4'h0, ALU_SHR});
        instr_q.push_back({OP_ALU, REG_V0, REG_VF, ALU_SHL});
        instr_q.push_back({OP_LD, REG_VF, 8'h80});
        instr_q.push_back({OP_ALU, REG_VF, 4'h0, ALU_SHL});       // VF as destination
        instr_q.push_back({OP_ALU, REG_VF, 4'h0, ALU_SUBN});
        instr_q.push_back({OP_SE, REG_VF, 8'h01});
        instr_q.push_back({OP_SNE, REG_VF, 8'h00});
        instr_q.push_back({OP_SEV, 4'h2, 4'h3, 4'h0});
        instr_q.push_back({OP_SEV, 4'h2, 4'h3, 4'hF});
        instr_q.push_back({OP_SNEV, REG_V0, 4'h1, 4'h0});
        instr_q.push_back({OP_SNEV, REG_V0, 4'h1, 4'h1});
        instr_q.push_back({OP_ALU, 4'h2, 4'h3, ALU_UNDEF});
        instr_q.push_back({OP_ALU, 4'h2, REG_V0, ALU_MOV});
        instr_q.push_back({OP_ALU, 4'h2, 4'h1, ALU_OR});
        instr_q.push_back({OP_ALU, 4'h2, REG_VF, ALU_AND});
        instr_q.push_back({OP_ALU, 4'h2, REG_V0, ALU_XOR});
        instr_q.push_back({OP_RND, 12'h0FF});
        instr_q.push_back({OP_DRW, 12'h123});
        instr_q.push_back({OP_SKP, 4'h0, 8'h9E});
        instr_q.push_back({OP_MISC, 4'h0, FX_BCD});
        instr_q.push_back({OP_LDI, 12'hFFF});
        instr_q.push_back({OP_MISC, REG_V0, FX_ADD_I});           // index wraps
        instr_q.push_back({OP_MISC, REG_V0, FX_DT_LD});
        instr_q.push_back({OP_MISC, 4'h1, FX_LD_DT});
        instr_q.push_back({OP_MISC, REG_V0, FX_ST_LD});
        instr_q.push_back({OP_CALL, 12'hFFE});
        instr_q.push_back(INS_RET);
        instr_q.push_back({OP_JPV0, 12'hFFF});                    // target wraps
        instr_q.push_back({OP_JP, 12'hFFE});
        instr_q.push_back({OP_ADD, REG_VF, 8'hFF});               // pc wraps to zero here
        directed_count = instr_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            @(negedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            add_random_items(140);
            // The first phase also holds the result side off for a long stretch.
            if (ph == 0) hold_req = 1'b1;
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        $display("Sent %0d instructions (%0d directed) over four idling phases and one long stall;",
                 sent_count, directed_count);
        $display("%0d results checked: ok %0d, unsupported %0d, overflow %0d, underflow %0d.",
                 checked_count, status_seen[ST_OK], status_seen[ST_UNSUPP],
                 status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW]);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("Run did not finish in time.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
